FILE: sv/bicolor_led_pattern_sequencer_macros.svh
// Assertion shorthands used by the sequencer core.
`ifndef BICOLOR_LED_PATTERN_SEQUENCER_MACROS_SVH
`define BICOLOR_LED_PATTERN_SEQUENCER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define BLPS_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define BLPS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/blps_pkg.sv
package blps_pkg;

  // Input transaction codes; the remaining codes do nothing.
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_COMMIT_FG = 3'd2,
    ACT_COMMIT_BG = 3'd3,
    ACT_DROP_FG   = 3'd4
  } action_t;

  // Dwell slots within a step, in play order.
  localparam logic [1:0] DW_BOTH  = 2'd0;
  localparam logic [1:0] DW_RED   = 2'd1;
  localparam logic [1:0] DW_GREEN = 2'd2;
  localparam logic [1:0] DW_OFF   = 2'd3;

  localparam logic [7:0] SOLID_OFF_MS = 8'd255;

  // LED drive: bit 0 red, bit 1 green.
  localparam logic [1:0] DRV_OFF   = 2'b00;
  localparam logic [1:0] DRV_RED   = 2'b01;
  localparam logic [1:0] DRV_GREEN = 2'b10;
  localparam logic [1:0] DRV_BOTH  = 2'b11;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  step_index;
    logic [7:0]  both_ms;
    logic [7:0]  red_ms;
    logic [7:0]  green_ms;
    logic [7:0]  off_ms;
    logic [15:0] step_ms;
    logic [3:0]  step_count;
    logic        loop_forever;
  } item_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic foreground_active;
  } result_t;

  // One stored step: duration and the four dwells indexed by DW_*.
  typedef struct packed {
    logic [15:0]     ms;
    logic [3:0][7:0] dw;
  } step_t;

  localparam int STEP_W = $bits(step_t);

  function automatic logic [1:0] color_bits(input logic [1:0] slot);
    logic [1:0] drive;
    unique case (slot)
      DW_BOTH:  drive = DRV_BOTH;
      DW_RED:   drive = DRV_RED;
      DW_GREEN: drive = DRV_GREEN;
      default:  drive = DRV_OFF;
    endcase
    return drive;
  endfunction

endpackage

FILE: sv/blps_ifs.sv
interface blps_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  step_index;
  logic [7:0]  both_ms;
  logic [7:0]  red_ms;
  logic [7:0]  green_ms;
  logic [7:0]  off_ms;
  logic [15:0] step_ms;
  logic [3:0]  step_count;
  logic        loop_forever;

  modport source (
    output valid, action, step_index, both_ms, red_ms, green_ms, off_ms,
           step_ms, step_count, loop_forever,
    input  ready
  );
  modport sink (
    input  valid, action, step_index, both_ms, red_ms, green_ms, off_ms,
           step_ms, step_count, loop_forever,
    output ready
  );
endinterface

interface blps_led_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;
  logic foreground_active;

  modport source (output valid, red_on, green_on, foreground_active, input ready);
  modport sink (input valid, red_on, green_on, foreground_active, output ready);
endinterface

FILE: sv/blps_ram.sv
module blps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/blps_core.sv
`include "bicolor_led_pattern_sequencer_macros.svh"

module blps_core #(
  parameter int MAX_STEPS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  blps_pkg::item_t   item,
  output blps_pkg::result_t result
);
  import blps_pkg::*;

  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int DEPTH = 3 * MAX_STEPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NT    = 3;

  localparam logic [1:0] TBL_BG_RST    = 2'd0;
  localparam logic [1:0] TBL_FG_RST    = 2'd1;
  localparam logic [1:0] TBL_SPARE_RST = 2'd2;

  // Per-table play position and bookkeeping.
  logic [SW-1:0]   next_step      [NT];
  logic [SW-1:0]   next_step_next [NT];
  logic [1:0]      shade          [NT];
  logic [1:0]      shade_next     [NT];
  logic [15:0]     step_left      [NT];
  logic [15:0]     step_left_next [NT];
  logic [7:0]      seg_left       [NT];
  logic [7:0]      seg_left_next  [NT];
  logic [SW-1:0]   table_len      [NT];
  logic [SW-1:0]   table_len_next [NT];
  logic            table_rep      [NT];
  logic            table_rep_next [NT];
  // Dwells of the step in play, and the prefetched step that loads next.
  logic [3:0][7:0] cur_dw         [NT];
  logic [3:0][7:0] cur_dw_next    [NT];
  step_t           up_entry       [NT];

  logic [1:0] ptr_bg, ptr_bg_next;
  logic [1:0] ptr_fg, ptr_fg_next;
  logic [1:0] ptr_spare, ptr_spare_next;
  logic       playing, playing_next;
  logic [1:0] led, led_next;

  // Step table port.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  step_t         wr_data;
  logic [AW-1:0] rd_addr;
  step_t         rd_data;
  logic          rd_en;
  logic [1:0]    rd_tbl;
  logic [SW-1:0] rd_idx;
  logic          pend_valid;
  logic [1:0]    pend_tbl;

  // Tick datapath.
  logic [1:0]      t0, tsel, sp;
  logic            fallback, need_load, empty, solid, found;
  step_t           up;
  logic [SW-1:0]   load_base, nx, len_clamped;
  logic [15:0]     lv;
  logic [7:0]      sl, seg_new;
  logic [1:0]      sh, sh_new, k, led_tick;
  logic [3:0][7:0] dw;

  blps_ram #(.WIDTH(STEP_W), .DEPTH(DEPTH)) u_steps (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    // Pick the playing table; a finished one-shot foreground hands over to background.
    t0        = playing ? ptr_fg : ptr_bg;
    fallback  = playing && (step_left[ptr_fg] == '0) &&
                (next_step[ptr_fg] >= table_len[ptr_fg]) && !table_rep[ptr_fg];
    tsel      = fallback ? ptr_bg : t0;
    need_load = (step_left[tsel] == '0);
    empty     = need_load && (table_len[tsel] == '0);
    sp        = ptr_spare;

    // Prefetched step; bypass the read that lands this cycle.
    up        = (pend_valid && (pend_tbl == tsel)) ? rd_data : up_entry[tsel];
    load_base = (next_step[tsel] >= table_len[tsel]) ? '0 : next_step[tsel];
    nx        = load_base + SW'(1);

    lv = need_load ? ((up.ms != '0) ? up.ms : 16'd1) : step_left[tsel];
    sl = need_load ? 8'd0 : seg_left[tsel];
    sh = need_load ? DW_BOTH : shade[tsel];
    dw = need_load ? up.dw : cur_dw[tsel];

    solid = (dw[DW_BOTH] == '0) && (dw[DW_RED] == '0) && (dw[DW_GREEN] == '0);
    k     = sh;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && (dw[sh + 2'(i)] != '0)) begin
        k     = sh + 2'(i);
        found = 1'b1;
      end
    end

    seg_new  = sl;
    sh_new   = sh;
    led_tick = led;
    if (sl == '0) begin
      if (solid) begin
        led_tick = DRV_OFF;
        seg_new  = (dw[DW_OFF] == SOLID_OFF_MS) ? SOLID_OFF_MS : 8'd1;
      end else begin
        led_tick = color_bits(k);
        seg_new  = dw[k];
        sh_new   = k + 2'd1;
      end
    end

    if (int'(item.step_count) > MAX_STEPS) begin
      len_clamped = SW'(MAX_STEPS);
    end else begin
      len_clamped = SW'(item.step_count);
    end

    // Hold everything by default.
    next_step_next = next_step;
    shade_next     = shade;
    step_left_next = step_left;
    seg_left_next  = seg_left;
    table_len_next = table_len;
    table_rep_next = table_rep;
    cur_dw_next    = cur_dw;
    ptr_bg_next    = ptr_bg;
    ptr_fg_next    = ptr_fg;
    ptr_spare_next = ptr_spare;
    playing_next   = playing;
    led_next       = led;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_tbl         = tsel;
    rd_idx         = '0;

    unique case (item.action)
      ACT_TICK: begin
        playing_next = playing && !fallback;
        if (empty) begin
          led_next = DRV_OFF;
        end else begin
          led_next             = led_tick;
          step_left_next[tsel] = lv - 16'd1;
          seg_left_next[tsel]  = (seg_new != '0) ? seg_new - 8'd1 : 8'd0;
          shade_next[tsel]     = sh_new;
          if (need_load) begin
            // Advance to the step just loaded and prefetch the one after it.
            next_step_next[tsel] = nx;
            cur_dw_next[tsel]    = up.dw;
            rd_en                = 1'b1;
            rd_idx               = (nx >= table_len[tsel]) ? '0 : nx;
          end
        end
      end
      ACT_WRITE: begin
        wr_en = advance && (int'(item.step_index) < MAX_STEPS);
      end
      ACT_COMMIT_FG: begin
        if (!playing) begin
          // Drop the background's current dwell and charge it to the step.
          step_left_next[ptr_bg] = ({8'd0, seg_left[ptr_bg]} > step_left[ptr_bg]) ? 16'd0 :
                                   step_left[ptr_bg] - {8'd0, seg_left[ptr_bg]};
          seg_left_next[ptr_bg]  = 8'd0;
        end
        table_len_next[sp] = len_clamped;
        table_rep_next[sp] = item.loop_forever;
        next_step_next[sp] = '0;
        shade_next[sp]     = DW_BOTH;
        step_left_next[sp] = 16'd0;
        seg_left_next[sp]  = 8'd0;
        ptr_fg_next        = sp;
        ptr_spare_next     = ptr_fg;
        playing_next       = 1'b1;
        rd_en              = 1'b1;
        rd_tbl             = sp;
      end
      ACT_COMMIT_BG: begin
        table_len_next[sp] = len_clamped;
        table_rep_next[sp] = 1'b1;
        next_step_next[sp] = '0;
        shade_next[sp]     = DW_BOTH;
        step_left_next[sp] = 16'd0;
        seg_left_next[sp]  = 8'd0;
        ptr_bg_next        = sp;
        ptr_spare_next     = ptr_bg;
        rd_en              = 1'b1;
        rd_tbl             = sp;
      end
      ACT_DROP_FG: begin
        playing_next = 1'b0;
      end
      default: begin
      end
    endcase

    wr_addr             = AW'(sp) * AW'(MAX_STEPS) + AW'(item.step_index);
    wr_data.ms          = item.step_ms;
    wr_data.dw[DW_BOTH] = item.both_ms;
    wr_data.dw[DW_RED]  = item.red_ms;
    wr_data.dw[DW_GREEN] = item.green_ms;
    wr_data.dw[DW_OFF]  = item.off_ms;
    rd_addr             = AW'(rd_tbl) * AW'(MAX_STEPS) + AW'(rd_idx);
  end

  assign result.red_on            = led_next[0];
  assign result.green_on          = led_next[1];
  assign result.foreground_active = playing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NT; j++) begin
        next_step[j] <= '0;
        shade[j]     <= DW_BOTH;
        step_left[j] <= '0;
        seg_left[j]  <= '0;
        table_len[j] <= '0;
        table_rep[j] <= 1'b1;
      end
      ptr_bg     <= TBL_BG_RST;
      ptr_fg     <= TBL_FG_RST;
      ptr_spare  <= TBL_SPARE_RST;
      playing    <= 1'b0;
      led        <= DRV_OFF;
      pend_valid <= 1'b0;
    end else begin
      if (advance) begin
        next_step <= next_step_next;
        shade     <= shade_next;
        step_left <= step_left_next;
        seg_left  <= seg_left_next;
        table_len <= table_len_next;
        table_rep <= table_rep_next;
        ptr_bg    <= ptr_bg_next;
        ptr_fg    <= ptr_fg_next;
        ptr_spare <= ptr_spare_next;
        playing   <= playing_next;
        led       <= led_next;
      end
      pend_valid <= advance && rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur_dw <= cur_dw_next;
    end
    if (pend_valid) begin
      up_entry[pend_tbl] <= rd_data;
    end
    pend_tbl <= rd_tbl;
  end

  `BLPS_CHECK(a_roles_distinct, clk, rst, 1'b1, ptr_bg != ptr_fg && ptr_bg != ptr_spare && ptr_fg != ptr_spare, "table roles overlap")
  `BLPS_CHECK_NEXT(a_led_only_on_tick, clk, rst, advance && item.action != ACT_TICK, $stable(led), "LED changed on a command")
  `BLPS_CHECK_NEXT(a_fg_commit_plays, clk, rst, advance && item.action == ACT_COMMIT_FG, playing, "foreground commit not playing")

endmodule

FILE: sv/bicolor_led_pattern_sequencer.sv
// Red/green LED pattern sequencer. Feed one cmd transaction per millisecond
// tick, with step writes and commits in between: writes fill the spare step
// table, a commit swaps it in as foreground or background, and ticks play the
// active table's steps by cycling through each step's non-zero dwells (both,
// red, green, off), clipping the last dwell to the step's time. The
// background always repeats; a one-shot foreground falls back to it when it
// ends. Every cmd transaction yields exactly one led transaction with the
// drive after it. Throughput is one transaction per cycle while the led side
// is ready; an accepted transaction is held in the input register, then goes
// through the sequencer logic into the result register. The step table
// lives in a RAM with a registered read; each table keeps its next step
// prefetched, so a tick never waits on the RAM.
module bicolor_led_pattern_sequencer #(
  parameter int MAX_STEPS = 10
) (
  input logic        clk,
  input logic        rst,
  blps_cmd_if.sink   cmd,
  blps_led_if.source led
);
  import blps_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;

  // Move the held transaction on when the result register is free or draining.
  assign advance   = in_valid && (!out_valid || led.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        in_valid <= cmd.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (led.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.action       <= cmd.action;
      in_item.step_index   <= cmd.step_index;
      in_item.both_ms      <= cmd.both_ms;
      in_item.red_ms       <= cmd.red_ms;
      in_item.green_ms     <= cmd.green_ms;
      in_item.off_ms       <= cmd.off_ms;
      in_item.step_ms      <= cmd.step_ms;
      in_item.step_count   <= cmd.step_count;
      in_item.loop_forever <= cmd.loop_forever;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  blps_core #(.MAX_STEPS(MAX_STEPS)) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (core_res)
  );

  assign led.valid             = out_valid;
  assign led.red_on            = out_res.red_on;
  assign led.green_on          = out_res.green_on;
  assign led.foreground_active = out_res.foreground_active;

endmodule

FILE: tb/bicolor_led_pattern_sequencer_tb.sv
module bicolor_led_pattern_sequencer_tb;
  import blps_pkg::*;

  localparam int STEPS = 10;             // steps per table in the block under test
  localparam int ITEM_TARGET = 950;      // transactions that do something
  localparam int DRAIN_CYCLES = 8;       // result path runs through the input and result registers
  localparam int STALL_LIMIT = 2000;     // cycles without any transaction
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_ROWS = 27;

  // Table roles, as indexes into role_tbl.
  localparam int ROLE_BG = 0;
  localparam int ROLE_FG = 1;
  localparam int ROLE_SPARE = 2;

  // Action codes that the block ignores.
  localparam logic [2:0] ACT_NOP_FIRST = 3'd5;
  localparam logic [2:0] ACT_NOP_LAST = 3'd7;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  blps_cmd_if cmd();
  blps_led_if led();

  bicolor_led_pattern_sequencer #(
    .MAX_STEPS(STEPS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .led(led)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state as the testbench sees it: three step tables, which of them
  // plays which role, a play cursor per table and the LED drive.
  // ---------------------------------------------------------------------------
  step_t             step_mem [3][STEPS];
  bit                step_written [3][STEPS];
  logic [3:0]        seq_len [3];
  logic              seq_loops [3];
  int                role_tbl [3];
  logic [3:0]        cur_next [3];     // next step to load
  logic [1:0]        cur_shade [3];    // dwell slot to try first
  int unsigned       step_left [3];    // ms left in the current step
  int unsigned       dwell_left [3];   // ms left in the current dwell
  logic              fg_playing;
  logic [1:0]        led_drive;

  result_t           pending_leds [$];
  result_t           want;
  dir_row_t          directed_rows [DIRECTED_ROWS];

  int led_errors = 0;
  int leds_checked = 0;
  int useful_items = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_commits = 0;
  int n_drops = 0;
  int n_ignored = 0;
  int sender_quiet = 0;
  int ready_hold = 0;
  int stall = 0;
  int idle_cycles = 0;

  // Swap the spare table in for a role; the old one becomes the spare.
  task automatic commit_spare(input int role, input logic [3:0] count, input logic loops);
    int sp;
    int old;
    sp = role_tbl[ROLE_SPARE];
    old = role_tbl[role];
    seq_len[sp] = (count > STEPS) ? 4'(STEPS) : count;
    seq_loops[sp] = loops;
    cur_next[sp] = '0;
    cur_shade[sp] = '0;
    step_left[sp] = 0;
    dwell_left[sp] = 0;
    role_tbl[role] = sp;
    role_tbl[ROLE_SPARE] = old;
  endtask

  // Apply one transaction to the state and return the LED result it yields.
  task automatic predict_led(input item_t it, output result_t res);
    int t;
    int s;
    bit silent;
    step_t st;
    logic [1:0] k;
    silent = 1'b0;
    case (it.action)
      ACT_TICK: begin
        t = role_tbl[fg_playing ? ROLE_FG : ROLE_BG];
        // A one-shot foreground that ran out hands over to the background.
        if (step_left[t] == 0 && cur_next[t] >= seq_len[t] && fg_playing && !seq_loops[t]) begin
          fg_playing = 1'b0;
          t = role_tbl[ROLE_BG];
        end
        if (step_left[t] == 0) begin
          if (cur_next[t] >= seq_len[t]) begin
            if (seq_len[t] == 0) silent = 1'b1;
            else cur_next[t] = '0;
          end
          if (!silent) begin
            s = cur_next[t];
            step_left[t] = (step_mem[t][s].ms != 0) ? step_mem[t][s].ms : 1;
            cur_shade[t] = '0;
            dwell_left[t] = 0;
            cur_next[t] = 4'(s + 1);
          end
        end
        if (silent || step_left[t] == 0) begin
          led_drive = DRV_OFF;
        end else begin
          if (dwell_left[t] == 0) begin
            s = (cur_next[t] == 0) ? 0 : cur_next[t] - 1;
            st = step_mem[t][s];
            if (st.dw[DW_BOTH] == 0 && st.dw[DW_RED] == 0 && st.dw[DW_GREEN] == 0) begin
              // Nothing lit in this step: dark, held long only for solid off.
              led_drive = DRV_OFF;
              dwell_left[t] = (st.dw[DW_OFF] == SOLID_OFF_MS) ? 255 : 1;
            end else begin
              k = cur_shade[t];
              while (st.dw[k] == 0) k = k + 2'd1;
              case (k)
                DW_BOTH:  led_drive = DRV_BOTH;
                DW_RED:   led_drive = DRV_RED;
                DW_GREEN: led_drive = DRV_GREEN;
                default:  led_drive = DRV_OFF;
              endcase
              dwell_left[t] = st.dw[k];
              cur_shade[t] = k + 2'd1;
            end
          end
          step_left[t]--;
          if (dwell_left[t] != 0) dwell_left[t]--;
        end
      end
      ACT_WRITE: begin
        if (it.step_index < STEPS) begin
          t = role_tbl[ROLE_SPARE];
          step_mem[t][it.step_index].ms = it.step_ms;
          step_mem[t][it.step_index].dw[DW_BOTH] = it.both_ms;
          step_mem[t][it.step_index].dw[DW_RED] = it.red_ms;
          step_mem[t][it.step_index].dw[DW_GREEN] = it.green_ms;
          step_mem[t][it.step_index].dw[DW_OFF] = it.off_ms;
          step_written[t][it.step_index] = 1'b1;
        end
      end
      ACT_COMMIT_FG: begin
        // Charge the rest of the background dwell to its step and drop it.
        if (!fg_playing) begin
          t = role_tbl[ROLE_BG];
          step_left[t] = (dwell_left[t] > step_left[t]) ? 0 : step_left[t] - dwell_left[t];
          dwell_left[t] = 0;
        end
        commit_spare(ROLE_FG, it.step_count, it.loop_forever);
        fg_playing = 1'b1;
      end
      ACT_COMMIT_BG: commit_spare(ROLE_BG, it.step_count, 1'b1);
      ACT_DROP_FG:   fg_playing = 1'b0;
      default: ;
    endcase
    res.red_on = led_drive[0];
    res.green_on = led_drive[1];
    res.foreground_active = fg_playing;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short, a few long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t random_tick();
    item_t it;
    it = random_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  // A step write with mostly short dwells and steps, so that ticks reach
  // step and dwell boundaries often; now and then solid off, all dark,
  // zero step time or full-range values.
  function automatic item_t random_step(input int idx);
    item_t it;
    int pick;
    it = random_item();
    it.action = ACT_WRITE;
    it.step_index = 4'(idx);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.both_ms = '0;
      it.red_ms = '0;
      it.green_ms = '0;
      it.off_ms = SOLID_OFF_MS;
    end else if (pick < 13) begin
      it.both_ms = '0;
      it.red_ms = '0;
      it.green_ms = '0;
      it.off_ms = 8'($urandom_range(0, 254));
    end else if (pick >= 20) begin
      it.both_ms = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      it.red_ms = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      it.green_ms = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
      it.off_ms = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) it.step_ms = '0;
    else if (pick < 80) it.step_ms = 16'($urandom_range(1, 24));
    else if (pick < 92) it.step_ms = 16'($urandom_range(25, 300));
    return it;
  endfunction

  // Steps 0.. of the spare table that have been written; a commit may not
  // ask for more, so no unwritten step is ever played.
  function automatic int spare_prefix();
    int sp;
    int n;
    sp = role_tbl[ROLE_SPARE];
    n = 0;
    while (n < STEPS && step_written[sp][n]) n++;
    return n;
  endfunction

  function automatic item_t random_commit();
    item_t it;
    int avail;
    it = random_item();
    it.action = ($urandom_range(0, 9) < 6) ? ACT_COMMIT_FG : ACT_COMMIT_BG;
    avail = spare_prefix();
    if (avail == STEPS && $urandom_range(0, 1) == 1) it.step_count = 4'($urandom_range(STEPS, 15));
    else if (avail == 0 || $urandom_range(0, 9) == 0) it.step_count = '0;
    else it.step_count = 4'($urandom_range(1, avail));
    return it;
  endfunction

  function automatic dir_row_t dir_row(input logic [2:0] act, input int idx, input int both,
                                       input int red, input int green, input int off,
                                       input int ms, input int count, input bit loops,
                                       input bit typed, input logic [1:0] drive, input bit fg);
    dir_row_t r;
    r.it.action = act;
    r.it.step_index = 4'(idx);
    r.it.both_ms = 8'(both);
    r.it.red_ms = 8'(red);
    r.it.green_ms = 8'(green);
    r.it.off_ms = 8'(off);
    r.it.step_ms = 16'(ms);
    r.it.step_count = 4'(count);
    r.it.loop_forever = loops;
    r.typed = typed;
    r.res.red_on = drive[0];
    r.res.green_on = drive[1];
    r.res.foreground_active = fg;
    return r;
  endfunction

  // Present one transaction, hold it until accepted, then record what the
  // LED side owes for it: the typed-in value where there is one, else the
  // prediction. Valid stays high into the next call when there is no gap.
  task automatic send(input item_t it, input bit typed, input result_t typed_res);
    int gap;
    result_t predicted;
    if (sender_quiet > 0) begin
      gap = 0;
      sender_quiet--;
    end else if ($urandom_range(0, 39) == 0) begin
      gap = 0;
      sender_quiet = $urandom_range(20, 60);
    end else begin
      gap = idle_length();
    end
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.action <= it.action;
    cmd.step_index <= it.step_index;
    cmd.both_ms <= it.both_ms;
    cmd.red_ms <= it.red_ms;
    cmd.green_ms <= it.green_ms;
    cmd.off_ms <= it.off_ms;
    cmd.step_ms <= it.step_ms;
    cmd.step_count <= it.step_count;
    cmd.loop_forever <= it.loop_forever;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_led(it, predicted);
    pending_leds.push_back(typed ? typed_res : predicted);
    case (it.action)
      ACT_TICK:      n_ticks++;
      ACT_WRITE:     if (it.step_index < STEPS) n_writes++;
      ACT_COMMIT_FG: n_commits++;
      ACT_COMMIT_BG: n_commits++;
      ACT_DROP_FG:   n_drops++;
      default: ;
    endcase
    if (it.action > ACT_DROP_FG || (it.action == ACT_WRITE && it.step_index >= STEPS))
      n_ignored++;
    else
      useful_items++;
  endtask

  // ---------------------------------------------------------------------------
  // LED side: random back-pressure with stretches of steady ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      led.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 49) == 0) begin
      led.ready <= 1'b1;
      ready_hold = $urandom_range(30, 80);
    end else begin
      stall = idle_length();
      led.ready <= (stall == 0);
      ready_hold = (stall == 0) ? $urandom_range(0, 4) : stall - 1;
    end
  end

  // Compare every LED transaction with the oldest result owed.
  always @(posedge clk) begin
    if (!rst && led.valid && led.ready) begin
      leds_checked++;
      if (pending_leds.size() == 0) begin
        led_errors++;
        if (led_errors <= REPORT_LIMIT)
          $display("unexpected LED result: red=%b green=%b fg=%b",
                   led.red_on, led.green_on, led.foreground_active);
      end else begin
        want = pending_leds.pop_front();
        if (led.red_on !== want.red_on || led.green_on !== want.green_on ||
            led.foreground_active !== want.foreground_active) begin
          led_errors++;
          if (led_errors <= REPORT_LIMIT)
            $display("LED result %0d: expected red=%b green=%b fg=%b, got red=%b green=%b fg=%b",
                     leds_checked, want.red_on, want.green_on, want.foreground_active,
                     led.red_on, led.green_on, led.foreground_active);
        end
      end
    end
  end

  // Watchdog: give up when neither side moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd.valid && cmd.ready) || (led.valid && led.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results still owed",
                 STALL_LIMIT, pending_leds.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main flow: reset, directed rows, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int j;
    int pick;
    int count;
    item_t it;

    // Hold every input at a known value from time zero.
    cmd.valid <= 1'b0;
    cmd.action <= ACT_TICK;
    cmd.step_index <= '0;
    cmd.both_ms <= '0;
    cmd.red_ms <= '0;
    cmd.green_ms <= '0;
    cmd.off_ms <= '0;
    cmd.step_ms <= '0;
    cmd.step_count <= '0;
    cmd.loop_forever <= 1'b0;

    // State after reset: three empty repeating tables, background shown.
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < STEPS; j++) begin
        step_mem[i][j] = '0;
        step_written[i][j] = 1'b0;
      end
      seq_len[i] = '0;
      seq_loops[i] = 1'b1;
      role_tbl[i] = i;
      cur_next[i] = '0;
      cur_shade[i] = '0;
      step_left[i] = 0;
      dwell_left[i] = 0;
    end
    fg_playing = 1'b0;
    led_drive = DRV_OFF;

    // Directed rows. Typed-in results cover reset, ignored items, the first
    // one-shot foreground played ms by ms, and empty sequences.
    //                           act            idx both red grn  off   ms  cnt lp  typ drive   fg
    directed_rows[0]  = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  0);
    directed_rows[1]  = dir_row(ACT_NOP_FIRST,   0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  0);
    // Out-of-range index with every field at its top: dropped.
    directed_rows[2]  = dir_row(ACT_WRITE,      15, 255,255,255, 255,65535, 15, 1, 1, DRV_OFF,  0);
    directed_rows[3]  = dir_row(ACT_WRITE,       0,   2,  1,  1,   0,    6,  0, 0, 1, DRV_OFF,  0);
    // Solid off with a zero step time, which lasts one ms.
    directed_rows[4]  = dir_row(ACT_WRITE,       1,   0,  0,  0, 255,    0,  0, 0, 1, DRV_OFF,  0);
    directed_rows[5]  = dir_row(ACT_COMMIT_FG,   0,   0,  0,  0,   0,    0,  2, 0, 1, DRV_OFF,  1);
    directed_rows[6]  = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_BOTH, 1);
    directed_rows[7]  = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_BOTH, 1);
    directed_rows[8]  = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_RED,  1);
    directed_rows[9]  = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_GREEN,1);
    directed_rows[10] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_BOTH, 1);
    // Second "both" dwell ends together with the step.
    directed_rows[11] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_BOTH, 1);
    directed_rows[12] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  1);
    // One-shot foreground ends and falls back to the empty background.
    directed_rows[13] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  0);
    directed_rows[14] = dir_row(ACT_WRITE,       0,   0,  3,  0,   1,    5,  0, 0, 0, DRV_OFF,  0);
    // Background commit ignores its repeat flag and shows from the next tick.
    directed_rows[15] = dir_row(ACT_COMMIT_BG,   0,   0,  0,  0,   0,    0,  1, 0, 1, DRV_OFF,  0);
    directed_rows[16] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);
    directed_rows[17] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);
    directed_rows[18] = dir_row(ACT_WRITE,       0,   1,  0,  1,   0,  100,  0, 0, 0, DRV_OFF,  0);
    // Foreground over a playing background: the background dwell is cut.
    directed_rows[19] = dir_row(ACT_COMMIT_FG,   0,   0,  0,  0,   0,    0,  1, 1, 0, DRV_OFF,  0);
    directed_rows[20] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);
    directed_rows[21] = dir_row(ACT_DROP_FG,     0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);
    directed_rows[22] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);
    // Empty repeating foreground shows off; empty one-shot falls back.
    directed_rows[23] = dir_row(ACT_COMMIT_FG,   0,   0,  0,  0,   0,    0,  0, 1, 0, DRV_OFF,  0);
    directed_rows[24] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  1);
    directed_rows[25] = dir_row(ACT_COMMIT_FG,   0,   0,  0,  0,   0,    0,  0, 0, 1, DRV_OFF,  1);
    directed_rows[26] = dir_row(ACT_TICK,        0,   0,  0,  0,   0,    0,  0, 0, 0, DRV_OFF,  0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++)
      send(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

    // Random traffic: mostly build a pattern, commit it and let it play;
    // the rest is plain ticks, recommits of what the spare holds, drops,
    // stray writes and ignored items.
    while (useful_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        count = ($urandom_range(0, 5) == 0) ? STEPS : $urandom_range(1, 4);
        for (i = 0; i < count; i++) begin
          send(random_step(i), 1'b0, '0);
          if ($urandom_range(0, 4) == 0) send(random_tick(), 1'b0, '0);
        end
        send(random_commit(), 1'b0, '0);
        count = $urandom_range(4, 40);
        for (i = 0; i < count; i++) begin
          it = random_tick();
          if ($urandom_range(0, 29) == 0) it.action = ACT_DROP_FG;
          send(it, 1'b0, '0);
        end
      end else if (pick < 75) begin
        count = $urandom_range(1, 30);
        for (i = 0; i < count; i++) send(random_tick(), 1'b0, '0);
      end else if (pick < 85) begin
        it = random_item();
        if ($urandom_range(0, 1) == 1) begin
          it.action = 3'($urandom_range(ACT_NOP_FIRST, ACT_NOP_LAST));
        end else begin
          it.action = ACT_WRITE;
          it.step_index = 4'($urandom_range(STEPS, 15));
        end
        send(it, 1'b0, '0);
      end else if (pick < 93) begin
        send(random_commit(), 1'b0, '0);
      end else if (pick < 97) begin
        it = random_item();
        it.action = ACT_DROP_FG;
        send(it, 1'b0, '0);
      end else begin
        send(random_step($urandom_range(0, STEPS - 1)), 1'b0, '0);
      end
    end
    cmd.valid <= 1'b0;

    // Drain: wait for every owed result, then a little longer for strays.
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d ticks, %0d step writes, %0d commits, %0d drops, %0d ignored items",
             n_ticks, n_writes, n_commits, n_drops, n_ignored);
    $display("%0d LED results checked, %0d mismatches", leds_checked, led_errors);
    if (led_errors == 0 && pending_leds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/blps_pkg.sv
sv/blps_ifs.sv
sv/blps_ram.sv
sv/blps_core.sv
sv/bicolor_led_pattern_sequencer.sv
tb/bicolor_led_pattern_sequencer_tb.sv
